// ===== rtl/mclp_pkg.sv =====
`default_nettype none

package mclp_pkg;

  localparam int unsigned LINE_LEN = 4;
  localparam int unsigned IDX_W = 3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_M     = 8'h4d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic signed [7:0] SPEED_MAX = 8'sd100;
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;

  typedef enum logic [1:0] {
    ECHO_NONE = 2'd0,
    ECHO_BYTE = 2'd1,
    ECHO_CRLF = 2'd2
  } echo_mode_t;

  typedef enum logic [1:0] {
    STAT_SPEED     = 2'd0,
    STAT_DISABLE   = 2'd1,
    STAT_BAD_CMD   = 2'd2,
    STAT_BAD_SPEED = 2'd3
  } cmd_status_t;

  typedef logic [LINE_LEN-1:0][7:0] line_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    echo_mode_t        echo_mode;
    logic [7:0]        echo_byte;
    logic              line_done;
    cmd_status_t       command_status;
    logic [1:0]        motor_number;
    logic signed [7:0] speed_value;
  } out_item_t;

  typedef struct packed {
    cmd_status_t       status;
    logic [1:0]        motor;
    logic signed [7:0] speed;
  } cmd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mclp_if.sv =====
`default_nettype none

interface mclp_in_if
  import mclp_pkg::*;
  (input wire logic clk);
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mclp_out_if
  import mclp_pkg::*;
  (input wire logic clk);
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mclp_cmd_parse.sv =====
`default_nettype none

module mclp_cmd_parse
  import mclp_pkg::*;
(
  input  line_t       line,
  output cmd_result_t result
);

  hex_t              ha;
  hex_t              hb;
  logic signed [8:0] v;
  logic signed [7:0] s;
  logic [7:0]        motor_diff;
  logic              is_bang;
  logic              is_move;

  assign ha = hex_decode(line[2]);
  assign hb = hex_decode(line[3]);

  // strtol base 16 on the last two characters
  always_comb begin
    v = 9'sd0;
    if (is_space(line[2])) begin
      if (hb.ok) v = $signed({5'd0, hb.val});
    end else if (line[2] == CH_PLUS || line[2] == CH_MINUS) begin
      if (hb.ok) begin
        if (line[2] == CH_MINUS) v = -$signed({5'd0, hb.val});
        else v = $signed({5'd0, hb.val});
      end
    end else if (ha.ok) begin
      if (hb.ok) v = $signed({1'b0, ha.val, hb.val});
      else v = $signed({5'd0, ha.val});
    end
  end

  assign s          = $signed(v[7:0]);
  assign motor_diff = line[1] - CH_ZERO;
  assign is_bang    = (line[0] == CH_BANG) && (line[1] == CH_BANG) &&
                      (line[2] == CH_BANG) && (line[3] == CH_BANG);
  assign is_move    = (line[0] == CH_M) && (line[1] >= CH_ONE) && (line[1] <= CH_TWO);

  always_comb begin
    result.status = STAT_SPEED;
    result.motor  = 2'd0;
    result.speed  = 8'sd0;
    if (is_bang) begin
      result.status = STAT_DISABLE;
    end else if (!is_move) begin
      result.status = STAT_BAD_CMD;
    end else if (s < SPEED_MIN || s > SPEED_MAX) begin
      result.status = STAT_BAD_SPEED;
    end else begin
      result.motor = motor_diff[1:0];
      result.speed = s;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/motor_command_line_parser_top.sv =====
`default_nettype none

// Motor command line parser. Each rx beat carries one terminal byte and
// produces exactly one tx beat: the echo action plus, on a carriage return,
// the decoded command ("!!!!" disable, "M1hh"/"M2hh" hex speed limited to
// -100..100). Each byte passes from the input register into the output
// register, where the result is held; one byte is taken every cycle while
// tx does not stall. The result is presented on tx once its byte reaches
// the output register and leaves when tx is ready; while tx stalls with a
// result waiting and a byte in the input register, rx is held off.
// The four-byte line buffer and the write index live in this module and
// are updated when a byte moves into the output register.

module motor_command_line_parser_top
  import mclp_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  mclp_in_if.sink     rx,
  mclp_out_if.source  tx
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  line_t            line;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] write_index_next;
  logic             is_cr;
  logic             is_back;
  logic             is_store;
  cmd_result_t      cmd;
  out_item_t        result;
  logic             out_valid;
  out_item_t        out_data;

  mclp_cmd_parse u_parse (
    .line   (line),
    .result (cmd)
  );

  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_byte <= rx.data.rx_byte;
    end
  end

  assign is_cr    = (in_byte == CH_CR);
  assign is_back  = !is_cr && (in_byte == CH_DEL) && (write_index != '0);
  assign is_store = !is_cr && !is_back && (write_index < IDX_W'(LINE_LEN));

  always_comb begin
    write_index_next = write_index;
    result           = '0;
    if (is_cr) begin
      write_index_next      = '0;
      result.echo_mode      = ECHO_CRLF;
      result.line_done      = 1'b1;
      result.command_status = cmd.status;
      result.motor_number   = cmd.motor;
      result.speed_value    = cmd.speed;
    end else if (is_back) begin
      write_index_next = write_index - IDX_W'(1);
      result.echo_mode = ECHO_BYTE;
      result.echo_byte = in_byte;
    end else if (is_store) begin
      write_index_next = write_index + IDX_W'(1);
      result.echo_mode = ECHO_BYTE;
      result.echo_byte = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      line        <= '0;
    end else if (advance) begin
      write_index <= write_index_next;
      if (is_store) begin
        line[write_index[1:0]] <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  assign tx.valid = out_valid;
  assign tx.data  = out_data;

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    write_index <= IDX_W'(LINE_LEN))
    else $error("write index beyond line length");

  a_cr_clears_index: assert property (@(posedge clk) disable iff (rst)
    (advance && is_cr) |=> (write_index == '0))
    else $error("carriage return left index nonzero");

  a_done_crlf: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.data.line_done) |-> (tx.data.echo_mode == ECHO_CRLF))
    else $error("line end without cr lf echo");

  a_speed_only_when_set: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.data.command_status != STAT_SPEED) |->
      (tx.data.speed_value == 8'sd0 && tx.data.motor_number == 2'd0))
    else $error("speed reported without speed command");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !tx.valid |-> rx.ready)
    else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mclp_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam int RANDOM_ITEMS = 1000;
  localparam int MAX_REPORTS  = 10;

  // tracks the line buffer and write index, predicts one tx beat per rx beat
  class command_checker;
    logic [7:0]       line_q [LINE_LEN];
    logic [IDX_W-1:0] wr_idx;
    out_item_t        expected_replies [$];
    int               errors;
    int               taken_cnt;

    function new();
      foreach (line_q[i]) line_q[i] = '0;
      wr_idx    = '0;
      errors    = 0;
      taken_cnt = 0;
    endfunction

    function int nibble(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
      if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
      return -1;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // base-16 text conversion limited to the last two buffer bytes
    function int hex_pair(logic [7:0] a, logic [7:0] b);
      int da;
      int db;
      db = nibble(b);
      if (blank(a)) return (db < 0) ? 0 : db;
      if (a == CH_PLUS || a == CH_MINUS) begin
        if (db < 0) return 0;
        return (a == CH_MINUS) ? -db : db;
      end
      da = nibble(a);
      if (da < 0) return 0;
      if (db < 0) return da;
      return da * 16 + db;
    endfunction

    function cmd_result_t decode_line();
      cmd_result_t       r;
      int                v;
      logic signed [7:0] s;
      r = '0;
      if (line_q[0] == CH_BANG && line_q[1] == CH_BANG &&
          line_q[2] == CH_BANG && line_q[3] == CH_BANG) begin
        r.status = STAT_DISABLE;
      end else if (line_q[0] != CH_M || line_q[1] < CH_ONE || line_q[1] > CH_TWO) begin
        r.status = STAT_BAD_CMD;
      end else begin
        v = hex_pair(line_q[2], line_q[3]);
        s = v[7:0];
        if (s < SPEED_MIN || s > SPEED_MAX) begin
          r.status = STAT_BAD_SPEED;
        end else begin
          r.status = STAT_SPEED;
          r.motor  = 2'(line_q[1] - CH_ZERO);
          r.speed  = s;
        end
      end
      return r;
    endfunction

    function void note_rx_byte(logic [7:0] c);
      out_item_t   r;
      cmd_result_t cmd;
      r = '0;
      if (c == CH_CR) begin
        cmd              = decode_line();
        wr_idx           = '0;
        r.echo_mode      = ECHO_CRLF;
        r.line_done      = 1'b1;
        r.command_status = cmd.status;
        r.motor_number   = cmd.motor;
        r.speed_value    = cmd.speed;
      end else if (c == CH_DEL && wr_idx != 0) begin
        wr_idx      = wr_idx - 1'b1;
        r.echo_mode = ECHO_BYTE;
        r.echo_byte = c;
      end else if (wr_idx < LINE_LEN) begin
        line_q[wr_idx[1:0]] = c;
        wr_idx      = wr_idx + 1'b1;
        r.echo_mode = ECHO_BYTE;
        r.echo_byte = c;
      end
      // bytes dropped on a full buffer do not count as stimulus
      if (r.echo_mode != ECHO_NONE) taken_cnt++;
      expected_replies.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_tx_beat(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("tx beat with nothing expected: mode %0d byte %h done %0b",
                         got.echo_mode, got.echo_byte, got.line_done));
        return;
      end
      want = expected_replies.pop_front();
      if (got.echo_mode !== want.echo_mode || got.echo_byte !== want.echo_byte ||
          got.line_done !== want.line_done || got.command_status !== want.command_status ||
          got.motor_number !== want.motor_number || got.speed_value !== want.speed_value)
        report($sformatf({"exp mode %0d byte %h done %0b status %0d motor %0d speed %0d, ",
                          "got mode %0d byte %h done %0b status %0d motor %0d speed %0d"},
                         want.echo_mode, want.echo_byte, want.line_done,
                         want.command_status, want.motor_number, want.speed_value,
                         got.echo_mode, got.echo_byte, got.line_done,
                         got.command_status, got.motor_number, got.speed_value));
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  mclp_in_if  rx_if (clk);
  mclp_out_if tx_if (clk);

  motor_command_line_parser_top dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  command_checker cmd_chk;
  int             burst_left;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic push_byte(input logic [7:0] b);
    in_item_t item;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item.rx_byte = b;
    rx_if.valid <= 1'b1;
    rx_if.data  <= item;
    do @(posedge clk); while (!rx_if.ready);
    cmd_chk.note_rx_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (cmd_chk.pending() != 0);
  endtask

  function automatic logic [7:0] arg_char();
    int d;
    d = $urandom_range(0, 15);
    case ($urandom_range(0, 10))
      0, 1, 2, 3, 4: begin
        if (d < 10) return 8'(CH_ZERO + d);
        return $urandom_range(0, 1) ? 8'(CH_LC_A + d - 10) : 8'(CH_UC_A + d - 10);
      end
      5:       return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_FF));
      6:       return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      7:       return $urandom_range(0, 1) ? CH_LC_X : CH_UC_X;
      8:       return CH_NUL;
      9:       return CH_ZERO;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_line();
    int         kind;
    int         n;
    logic [7:0] motor_ch;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      for (int i = 0; i < 4; i++)
        push_byte(($urandom_range(0, 7) == 0) ? arg_char() : CH_BANG);
    end else if (kind < 14) begin
      if ($urandom_range(0, 7) == 0)
        motor_ch = $urandom_range(0, 1) ? CH_ZERO : CH_THREE;
      else
        motor_ch = $urandom_range(0, 1) ? CH_ONE : CH_TWO;
      push_byte(($urandom_range(0, 15) == 0) ? arg_char() : CH_M);
      push_byte(motor_ch);
      push_byte(arg_char());
      // typo and rubout before the last character
      if (kind >= 12) begin
        push_byte(arg_char());
        push_byte(CH_DEL);
      end
      push_byte(arg_char());
    end else if (kind < 16) begin
      n = $urandom_range(5, 8);
      repeat (n) push_byte(8'($urandom_range(8'h20, 8'h7e)));
    end else if (kind < 18) begin
      // short line, parse sees bytes left from earlier lines
      n = $urandom_range(0, 3);
      repeat (n) push_byte(arg_char());
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end
    push_byte(CH_CR);
  endtask

  initial begin
    int baseline;
    int drain_wait;
    cmd_chk     = new();
    burst_left  = 0;
    rst         <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_text("!!!!");
    push_byte(CH_CR);
    send_text("M164");
    push_byte(CH_CR);
    send_text("M29c");
    push_byte(CH_CR);
    // rubout at index zero is stored, the next rubout erases it, then the fifth data byte falls off a full line
    push_byte(CH_DEL);
    push_byte(CH_DEL);
    push_byte(CH_NUL);
    push_byte(8'hff);
    push_byte(8'h80);
    push_byte(8'h7e);
    push_byte(8'h55);
    push_byte(CH_CR);
    send_text("M2");
    push_byte(CH_CR);
    wait_drained();

    baseline = cmd_chk.taken_cnt;
    while (cmd_chk.taken_cnt - baseline < RANDOM_ITEMS) begin
      send_random_line();
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    rx_if.valid <= 1'b0;

    drain_wait = 0;
    while (cmd_chk.pending() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (20) @(posedge clk);
    if (cmd_chk.pending() != 0)
      cmd_chk.report($sformatf("%0d results never arrived", cmd_chk.pending()));
    if (cmd_chk.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int         cyc;
    int         mode;
    logic [7:0] pat;
    tx_if.ready <= 1'b0;
    cyc  = 0;
    mode = 0;
    pat  = 8'hff;
    forever begin
      @(posedge clk);
      if (!rst && tx_if.valid && tx_if.ready) cmd_chk.check_tx_beat(tx_if.data);
      cyc++;
      if (cyc % 150 == 0) begin
        mode = $urandom_range(0, 3);
        pat  = 8'($urandom_range(1, 255));
      end
      case (mode)
        0:       tx_if.ready <= 1'b1;
        1:       tx_if.ready <= ($urandom_range(0, 3) != 0);
        2:       tx_if.ready <= pat[cyc % 8];
        default: tx_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
